/* design/ist_pkg.sv */
// Shared constants, request/status codes and the cell control struct
// for the id set table. No dependencies.
package ist_pkg;

	localparam int unsigned IST_DEPTH = 16;
	localparam int unsigned IDENT_W   = 64;
	localparam int unsigned POS_W     = 4;
	localparam int unsigned CNT_W     = 5;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_CHECK  = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTIED   = 2'd3;

	// Per-cycle commands broadcast to every cell of the row
	typedef struct packed {
		logic cmp;      // compare the incoming ident against the stored entry
		logic append;   // write the ident into the cell at the fill point
		logic shift;    // cells at or above the hit take their upper neighbor
	} ist_ctl_t;

endpackage

/* design/ist_cell.sv */
// One storage cell of the id set table row: an entry, its compare and
// its shift-down path. Depends on ist_pkg.
module ist_cell import ist_pkg::*; #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CW    = 5,
	parameter int unsigned PW    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ist_ctl_t            ctl,
	input  logic [IDENT_W-1:0]  ident,
	input  logic [CW-1:0]       count,
	input  logic [PW-1:0]       pos,
	input  logic [IDENT_W-1:0]  upper_entry,
	output logic [IDENT_W-1:0]  entry,
	output logic                match
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [PW-1:0] IDX_P = PW'(IDX);

	logic [IDENT_W-1:0] entry_q;
	logic               match_q;

	// entry store has no reset: count marks what is valid
	always_ff @(posedge clk) begin
		if (ctl.append && (count == IDX_C)) begin
			entry_q <= ident;
		end else if (ctl.shift && (IDX_P >= pos)) begin
			entry_q <= upper_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= (IDX_C < count) && (entry_q == ident);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

/* design/id_set_table.sv */
// Top level of the id set table: request/result stream ports, control
// and the row of ist_cell storage cells. Depends on ist_pkg, ist_cell.
//
// Usage:
//   A set of up to DEPTH distinct 64-bit identifiers. Each request item on
//   the s_ channel carries a request kind in s_tuser (add, remove, check,
//   clear) and an identifier in s_tdata. Every request gives exactly one
//   result item on the m_ channel: a status code in m_tuser and found,
//   position and entry_count in m_tdata.
//   Each accepted request is registered and compared; its update step then
//   loads the result into the output register once the output is free,
//   which raises m_tvalid. A new request is not accepted until the last
//   has finished its update step. The compare step checks the identifier
//   against every cell in parallel; the update step resolves the hit,
//   updates the cells (append at the fill point, or shift the cells above
//   a removed entry down by one) and loads the result. s_tready stays low
//   while a request sits between those two steps.
//   Stall: while a result waits on m_tready, the next request is still
//   accepted and compared; its update step holds until the result
//   register is taken, so no result is lost or reordered.
//   Reset: the count and the handshake state clear at once; the cells
//   themselves are not cleared, the count alone marks valid entries. No
//   clearing pass is needed, items are accepted right after reset.
module id_set_table import ist_pkg::*; #(
	parameter int unsigned DEPTH = IST_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // [63:0] ident
	input  logic [1:0]   s_tuser,   // [1:0] req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,   // [0] found, [4:1] position, [9:5] entry_count
	output logic [1:0]   m_tuser    // [1:0] status
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic                 s_fire;
	logic                 upd_fire;
	logic                 busy_q;
	logic [1:0]           req_s1;
	logic [IDENT_W-1:0]   ident_s1;
	logic [CW-1:0]        count_q;
	logic [DEPTH-1:0]     match;
	logic [IDENT_W-1:0]   entry   [DEPTH];
	logic [IDENT_W-1:0]   upper   [DEPTH];
	ist_ctl_t             ctl;

	logic                 hit;
	logic [PW-1:0]        pos;
	logic                 full;
	logic [CW-1:0]        count_nxt;
	logic [1:0]           status_nxt;

	logic [PW+POS_W-1:0]  pos_ext;
	logic [CW+CNT_W-1:0]  cnt_ext;

	logic                 m_tvalid_q;
	logic [1:0]           status_q;
	logic                 found_q;
	logic [POS_W-1:0]     position_q;
	logic [CNT_W-1:0]     entry_count_q;

	// Accept only when no request is waiting for its update step
	assign s_tready = !busy_q;
	assign s_fire   = s_tvalid && s_tready;
	// Advance the update step once the result register is free
	assign upd_fire = busy_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (s_fire) begin
			busy_q <= 1'b1;
		end else if (upd_fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_s1   <= s_tuser;
			ident_s1 <= s_tdata;
		end
	end

	// Entries are unique, so at most one cell matches: fold its index in
	always_comb begin
		hit = 1'b0;
		pos = '0;
		if (req_s1 != REQ_CLEAR) begin
			for (int unsigned i = 0; i < DEPTH; i++) begin
				if (match[i]) begin
					hit = 1'b1;
					pos = pos | PW'(i);
				end
			end
		end
	end

	assign full = (count_q == DEPTH_C);

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		ctl.cmp    = s_fire;
		ctl.append = 1'b0;
		ctl.shift  = 1'b0;
		unique case (req_s1)
			REQ_ADD: begin
				if (!hit) begin
					if (full) begin
						status_nxt = ST_FULL;
					end else begin
						ctl.append = upd_fire;
						count_nxt  = count_q + CW'(1);
					end
				end
			end
			REQ_REMOVE: begin
				if (!hit) begin
					status_nxt = ST_NOT_FOUND;
				end else begin
					ctl.shift  = upd_fire;
					count_nxt  = count_q - CW'(1);
					status_nxt = (count_nxt == '0) ? ST_EMPTIED : ST_OK;
				end
			end
			REQ_CHECK: begin
				status_nxt = hit ? ST_OK : ST_NOT_FOUND;
			end
			REQ_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (upd_fire) begin
			count_q <= count_nxt;
		end
	end

	// Row of cells; each takes its upper neighbor on a shift
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == DEPTH - 1) begin : g_top
			assign upper[g] = '0;
		end else begin : g_mid
			assign upper[g] = entry[g+1];
		end
		ist_cell #(
			.IDX (g),
			.CW  (CW),
			.PW  (PW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.ident       (ctl.cmp ? s_tdata : ident_s1),
			.count       (count_q),
			.pos         (pos),
			.upper_entry (upper[g]),
			.entry       (entry[g]),
			.match       (match[g])
		);
	end

	// Report the low bits of position and count
	assign pos_ext = {{POS_W{1'b0}}, pos};
	assign cnt_ext = {{CNT_W{1'b0}}, count_nxt};

	// Result register; drop it when the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (upd_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			status_q      <= status_nxt;
			found_q       <= hit;
			position_q    <= pos_ext[POS_W-1:0];
			entry_count_q <= cnt_ext[CNT_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {6'b0, entry_count_q, position_q, found_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above capacity");

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(match))
		else $error("identifier matched in more than one cell");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> m_tvalid && !busy_q)
		else $error("update step did not load a result");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> busy_q)
		else $error("accepted item not held for update");

endmodule
